/* sv/sqr_pkg.sv */
// Shared constants, codes and control types of the shifting queue.
`timescale 1ns / 1ps
`default_nettype none
package sqr_pkg;

  localparam int QDEPTH = 16;
  localparam int CNT_W  = $clog2(QDEPTH + 1);
  localparam int LVLS   = $clog2(QDEPTH);
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  localparam logic [1:0] OP_ENQ = 2'd0;
  localparam logic [1:0] OP_DEQ = 2'd1;
  localparam logic [1:0] OP_REV = 2'd2;
  localparam logic [1:0] OP_REM = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic accept;
    logic exec;
    logic rev_step;
    logic rev_finish;
    logic rem_apply;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       rev_done;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

/* sv/shifting_queue_with_remove_reverse_top.sv */
// Top level of the shifting queue with remove and reverse.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o   opcode_i, value_i
//   out      output     out_valid_o/out_ready_i data_out_o, status_o, occupancy_o
//
// Enqueue and dequeue accept the item, then update the queue and load the result.
// Remove accepts the item, compares every held entry with the value, then closes the gap.
// Reverse mirrors the whole array, then shifts it down one slot a cycle until the
// reverse counter, loaded with QDEPTH minus the occupancy, runs out.
// Reset clears entries and count at once; a held result stalls only the final step.
`timescale 1ns / 1ps
`default_nettype none
module shifting_queue_with_remove_reverse_top
  import sqr_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [1:0]               opcode_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [DATA_W-1:0]      data_out_o,
  output logic [1:0]                    status_o,
  output logic [OCC_W-1:0]              occupancy_o
);

  cmd_t cmd;
  sts_t sts;

  sqr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sqr_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_out_o  (data_out_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

endmodule
`default_nettype wire

/* sv/sqr_ctrl.sv */
// Sequencer of the shifting queue: accepts an item and steps the datapath.
`timescale 1ns / 1ps
`default_nettype none
module sqr_ctrl
  import sqr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_REV  = 2'd2;
  localparam logic [1:0] S_REM  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.op == OP_REV) begin
          cmd_o.exec = 1'b1;
          state_d    = S_REV;
        end else if (sts_i.op == OP_REM) begin
          cmd_o.exec = 1'b1;
          state_d    = S_REM;
        end else if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_REV: begin
        if (!sts_i.rev_done) begin
          cmd_o.rev_step = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.rev_finish = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_REM: begin
        if (sts_i.out_free) begin
          cmd_o.rem_apply = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.exec, cmd_o.rev_step, cmd_o.rev_finish, cmd_o.rem_apply}))
    else $error("more than one datapath command at once");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rev_finish || cmd_o.rem_apply ||
     (cmd_o.exec && (sts_i.op == OP_ENQ || sts_i.op == OP_DEQ))) |-> sts_i.out_free)
    else $error("result loaded while output register busy");

  a_rev_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rev_step |-> !sts_i.rev_done)
    else $error("reverse shift past its count");

endmodule
`default_nettype wire

/* sv/sqr_dpath.sv */
// Datapath of the shifting queue: entry array, count, search and output register.
`timescale 1ns / 1ps
`default_nettype none
module sqr_dpath
  import sqr_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [1:0]               opcode_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire cmd_t                     cmd_i,
  output sts_t                          sts_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [DATA_W-1:0]      data_out_o,
  output logic [1:0]                    status_o,
  output logic [OCC_W-1:0]              occupancy_o
);

  logic signed [DATA_W-1:0] ent_q [QDEPTH];
  logic signed [DATA_W-1:0] ent_d [QDEPTH];
  logic signed [DATA_W-1:0] shd   [QDEPTH];
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [CNT_W-1:0]         rev_q, rev_d;
  logic [QDEPTH-1:0]        match_q, match_d;
  logic [QDEPTH-1:0]        mask;
  logic [1:0]               op_q;
  logic signed [DATA_W-1:0] val_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] data_q, data_d;
  logic [1:0]               stat_q, stat_d;
  logic [OCC_W-1:0]         occ_q;
  logic                     load;

  always_comb begin
    for (int k = 0; k < QDEPTH - 1; k++) begin
      shd[k] = ent_q[k + 1];
    end
    shd[QDEPTH-1] = '0;
  end

  always_comb begin
    mask = match_q;
    for (int l = 0; l < LVLS; l++) begin
      for (int k = QDEPTH - 1; k >= (1 << l); k--) begin
        mask[k] = mask[k] | mask[k - (1 << l)];
      end
    end
  end

  always_comb begin
    ent_d   = ent_q;
    cnt_d   = cnt_q;
    rev_d   = rev_q;
    match_d = match_q;
    data_d  = '0;
    stat_d  = ST_OK;
    load    = 1'b0;
    if (cmd_i.exec) begin
      case (op_q)
        OP_ENQ: begin
          load = 1'b1;
          if (cnt_q == CNT_W'(QDEPTH)) begin
            stat_d = ST_FULL;
          end else begin
            for (int k = 0; k < QDEPTH; k++) begin
              if (CNT_W'(k) == cnt_q) ent_d[k] = val_q;
            end
            cnt_d = cnt_q + 1'b1;
          end
        end
        OP_DEQ: begin
          load = 1'b1;
          if (cnt_q == '0) begin
            stat_d = ST_EMPTY;
          end else begin
            data_d = ent_q[0];
            ent_d  = shd;
            cnt_d  = cnt_q - 1'b1;
          end
        end
        OP_REV: begin
          for (int k = 0; k < QDEPTH; k++) begin
            ent_d[k] = ent_q[QDEPTH-1-k];
          end
          rev_d = CNT_W'(QDEPTH) - cnt_q;
        end
        default: begin
          for (int k = 0; k < QDEPTH; k++) begin
            match_d[k] = (CNT_W'(k) < cnt_q) && (ent_q[k] == val_q);
          end
        end
      endcase
    end
    if (cmd_i.rev_step) begin
      ent_d = shd;
      rev_d = rev_q - 1'b1;
    end
    if (cmd_i.rev_finish) begin
      load = 1'b1;
    end
    if (cmd_i.rem_apply) begin
      load = 1'b1;
      if (cnt_q == '0) begin
        stat_d = ST_EMPTY;
      end else if (!mask[QDEPTH-1]) begin
        stat_d = ST_NOTFOUND;
      end else begin
        for (int k = 0; k < QDEPTH; k++) begin
          if (mask[k]) ent_d[k] = shd[k];
        end
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QDEPTH; k++) begin
        ent_q[k] <= '0;
      end
      cnt_q       <= '0;
      rev_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ent_q <= ent_d;
      cnt_q <= cnt_d;
      rev_q <= rev_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    match_q <= match_d;
    if (cmd_i.accept) begin
      op_q  <= opcode_i;
      val_q <= value_i;
    end
    if (load) begin
      data_q <= data_d;
      stat_q <= stat_d;
      occ_q  <= OCC_W'(cnt_d);
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.rev_done = (rev_q == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_q;
  assign status_o    = stat_q;
  assign occupancy_o = occ_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QDEPTH))
    else $error("fill count above queue depth");

  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && op_q == OP_DEQ && cnt_q != '0) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("dequeue did not drop the count by one");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the shifting queue: directed table, then paced random items.
`timescale 1ns / 1ps
module tb_top;
  import sqr_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RAND_ITEMS  = 500;
  localparam int DRAIN_WAIT  = 2 * (QDEPTH + 3) + 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic [OCC_W-1:0]         occ;
  } result_t;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
    int                       reps;
    logic                     literal;
    result_t                  lit;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic [1:0]               opcode = OP_ENQ;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_ready = 1'b0;
  logic                     in_ready_o;
  logic                     out_valid_o;
  logic signed [DATA_W-1:0] data_out_o;
  logic [1:0]               status_o;
  logic [OCC_W-1:0]         occupancy_o;

  logic signed [DATA_W-1:0] model_slots [QDEPTH];
  int                       model_fill;
  result_t                  pending_results [$];
  stim_row_t                plan [21];

  int send_idle = 17;
  int recv_idle = 60;
  int filling = 1;
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int cycle_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  shifting_queue_with_remove_reverse_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode),
    .value_i     (value),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .data_out_o  (data_out_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  function automatic void close_gap(input int pos);
    for (int k = pos; k + 1 < model_fill; k++) model_slots[k] = model_slots[k + 1];
    model_fill--;
    model_slots[model_fill] = '0;
  endfunction

  task automatic predict_queue_step(input logic [1:0] op,
                                    input logic signed [DATA_W-1:0] val,
                                    output result_t res);
    int                       hit;
    logic signed [DATA_W-1:0] tmp;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_ENQ: begin
        if (model_fill >= QDEPTH) begin
          res.status = ST_FULL;
        end else begin
          model_slots[model_fill] = val;
          model_fill++;
        end
      end
      OP_DEQ: begin
        if (model_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = model_slots[0];
          close_gap(0);
        end
      end
      OP_REV: begin
        for (int k = 0; k < model_fill / 2; k++) begin
          tmp = model_slots[k];
          model_slots[k] = model_slots[model_fill - 1 - k];
          model_slots[model_fill - 1 - k] = tmp;
        end
      end
      default: begin
        hit = -1;
        for (int k = 0; k < model_fill; k++) begin
          if (hit < 0 && model_slots[k] == val) hit = k;
        end
        if (model_fill == 0) begin
          res.status = ST_EMPTY;
        end else if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          close_gap(hit);
        end
      end
    endcase
    res.occ = OCC_W'(model_fill);
  endtask

  task automatic send_item(input logic [1:0] op, input logic signed [DATA_W-1:0] val,
                           input logic use_lit, input result_t lit);
    result_t predicted;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    predict_queue_step(op, val, predicted);
    pending_results.push_back(use_lit ? lit : predicted);
    items_sent++;
  endtask

  task automatic send_random_item();
    logic [1:0]               op;
    logic signed [DATA_W-1:0] val;
    int                       pick;
    pick = $urandom_range(99);
    if (filling != 0) begin
      op = (pick < 55) ? OP_ENQ : (pick < 72) ? OP_DEQ : (pick < 82) ? OP_REV : OP_REM;
    end else begin
      op = (pick < 20) ? OP_ENQ : (pick < 65) ? OP_DEQ : (pick < 75) ? OP_REV : OP_REM;
    end
    if ($urandom_range(99) < 35) begin
      val = $urandom;
    end else begin
      val = $signed(DATA_W'($urandom_range(8))) - 4;
    end
    if (op == OP_REM && model_fill > 0 && $urandom_range(99) < 60) begin
      val = model_slots[$urandom_range(model_fill - 1)];
    end
    send_item(op, val, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        if (data_out_o !== want.data)
          report_mismatch($sformatf("data_out %0d, want %0d", data_out_o, want.data));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
        if (occupancy_o !== want.occ)
          report_mismatch($sformatf("occupancy %0d, want %0d", occupancy_o, want.occ));
        results_checked++;
        if (!$isunknown(status_o)) status_seen[status_o]++;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    plan = '{
      '{OP_DEQ, 32'sd0,          1, 1'b1, '{32'sd0,  ST_EMPTY,    5'd0}},
      '{OP_REM, 32'sd7,          1, 1'b1, '{32'sd0,  ST_EMPTY,    5'd0}},
      '{OP_REV, 32'sd0,          1, 1'b1, '{32'sd0,  ST_OK,       5'd0}},
      '{OP_ENQ, 32'h8000_0000,   1, 1'b1, '{32'sd0,  ST_OK,       5'd1}},
      '{OP_REV, 32'sd0,          1, 1'b1, '{32'sd0,  ST_OK,       5'd1}},
      '{OP_ENQ, 32'h7FFF_FFFF,   1, 1'b1, '{32'sd0,  ST_OK,       5'd2}},
      '{OP_ENQ, 32'sd0,          1, 1'b1, '{32'sd0,  ST_OK,       5'd3}},
      '{OP_ENQ, -32'sd1,         1, 1'b1, '{32'sd0,  ST_OK,       5'd4}},
      '{OP_REV, 32'sd0,          1, 1'b1, '{32'sd0,  ST_OK,       5'd4}},
      '{OP_DEQ, 32'sd0,          1, 1'b1, '{-32'sd1, ST_OK,       5'd3}},
      '{OP_REM, 32'sd12345,      1, 1'b1, '{32'sd0,  ST_NOTFOUND, 5'd3}},
      '{OP_ENQ, 32'sd0,          1, 1'b1, '{32'sd0,  ST_OK,       5'd4}},
      '{OP_REM, 32'sd0,          1, 1'b1, '{32'sd0,  ST_OK,       5'd3}},
      '{OP_REM, 32'h8000_0000,   1, 1'b1, '{32'sd0,  ST_OK,       5'd2}},
      '{OP_ENQ, 32'sd1000,      14, 1'b0, '0},
      '{OP_ENQ, 32'sd55,         1, 1'b1, '{32'sd0,  ST_FULL,     5'd16}},
      '{OP_REM, 32'h7FFF_FFFF,   1, 1'b0, '0},
      '{OP_REM, 32'sd1013,       1, 1'b0, '0},
      '{OP_REV, 32'sd0,          1, 1'b0, '0},
      '{OP_DEQ, 32'sd0,          2, 1'b0, '0},
      '{OP_REM, 32'sd1005,       1, 1'b0, '0}
    };
    for (int k = 0; k < QDEPTH; k++) model_slots[k] = '0;
    model_fill = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      for (int i = 0; i < plan[r].reps; i++) begin
        send_item(plan[r].op, plan[r].value + i, plan[r].literal, plan[r].lit);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 17 : (phase == 1) ? 60 : 0;
      recv_idle = (phase == 0) ? 60 : (phase == 1) ? 17 : 0;
      if (phase == 1) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if (i % 64 == 0) filling = $urandom_range(1);
        send_random_item();
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d items (directed table plus three pacing phases), checked %0d results",
             items_sent, results_checked);
    $display("Status seen: ok %0d, full %0d, empty %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_NOTFOUND]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
